@@ rtl/edfq_pkg.sv @@
// ----------------------------------------------------------------------------
// edfq_pkg
// Shared types and constants for the earliest-deadline-first ready queue.
// ----------------------------------------------------------------------------
package edfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DL_W        = 32;
    localparam int KIND_W      = 3;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_W   = ((DL_W + KIND_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((KIND_W + DL_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef struct packed {
        logic [DL_W-1:0]   deadline;
        logic [KIND_W-1:0] kind;
    } entry_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [DL_W-1:0]   deadline;
        logic [KIND_W-1:0] kind;
    } cmd_t;

endpackage

@@ rtl/edfq_cell.sv @@
// ----------------------------------------------------------------------------
// edfq_cell
// One slot of the sorted queue: holds an entry, compares it with the pushed
// deadline and shifts toward the tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
module edfq_cell (
    input  logic            clk,
    input  edfq_pkg::cmd_t   cmd,
    input  logic            occupied,
    input  logic            prev_place,
    input  edfq_pkg::entry_t prev_entry,
    input  edfq_pkg::entry_t next_entry,
    output logic            place,
    output edfq_pkg::entry_t entry
);
    import edfq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // new word belongs at or before this slot (ties stay behind older words)
    assign place = !occupied || (entry_reg.deadline > cmd.deadline);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push)
        begin
            if (prev_place)
            begin
                entry_next = prev_entry;
            end
            else if (place)
            begin
                entry_next.deadline = cmd.deadline;
                entry_next.kind     = cmd.kind;
            end
        end
        else if (cmd.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ rtl/edf_ready_queue_core.sv @@
// ----------------------------------------------------------------------------
// edf_ready_queue_core
// Earliest-deadline-first ready queue built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready with s_tuser[0] as the mode
//   (0 push, 1 pop) and s_tdata carrying the deadline and the task kind.
//   Every input word produces exactly one result word on m_tvalid/m_tready;
//   m_tuser holds the status and m_tdata the popped kind and deadline.
//   A push inserts into a chain of cells kept sorted by deadline, older
//   words ahead of newer ones with equal deadline; a pop takes the head cell
//   and shifts the chain by one. Both finish in the cycle of acceptance.
//   m_tvalid rises in the cycle after acceptance; throughput is one word
//   per cycle while the receiver keeps up, set by the single compare in each cell.
//   The result sits in an output register; s_tready is low only while that
//   register is full and m_tready is low, so a stalled receiver holds the
//   block without losing anything.
//   Reset clears the fill count and the output valid flag; the queue is
//   empty right after reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module edf_ready_queue_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [edfq_pkg::IN_DATA_W-1:0]  s_tdata,   // deadline, task_kind
    input  logic [0:0]                      s_tuser,   // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [edfq_pkg::OUT_DATA_W-1:0] m_tdata,   // out_task_kind, out_deadline
    output logic [1:0]                      m_tuser    // status
);
    import edfq_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    status_t               out_status_reg;
    status_t               out_status_next;

    logic                  accept;
    logic                  is_pop;
    logic                  full;
    logic                  empty;
    cmd_t                  cmd;

    logic   [QUEUE_DEPTH-1:0] occ_w;
    logic   [QUEUE_DEPTH-1:0] place_w;
    logic   [QUEUE_DEPTH-1:0] prev_place_w;
    entry_t                   entry_w      [QUEUE_DEPTH];
    entry_t                   prev_entry_w [QUEUE_DEPTH];
    entry_t                   next_entry_w [QUEUE_DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_pop   = (mode_t'(s_tuser[0]) == MODE_POP);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    assign cmd.push     = accept && !is_pop && !full;
    assign cmd.pop      = accept && is_pop && !empty;
    assign cmd.deadline = s_tdata[DL_W-1:0];
    assign cmd.kind     = s_tdata[DL_W +: KIND_W];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            assign occ_w[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_head
                assign prev_place_w[gi] = 1'b0;
                assign prev_entry_w[gi] = '0;
            end
            else
            begin : g_body
                assign prev_place_w[gi] = place_w[gi-1];
                assign prev_entry_w[gi] = entry_w[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_entry_w[gi] = '0;
            end
            else
            begin : g_mid
                assign next_entry_w[gi] = entry_w[gi+1];
            end

            edfq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (occ_w[gi]),
                .prev_place (prev_place_w[gi]),
                .prev_entry (prev_entry_w[gi]),
                .next_entry (next_entry_w[gi]),
                .place      (place_w[gi]),
                .entry      (entry_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            if (is_pop)
            begin
                if (empty)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_status_next = ST_POPPED;
                    out_data_next   = OUT_DATA_W'({entry_w[0].deadline, entry_w[0].kind});
                end
            end
            else
            begin
                out_status_next = full ? ST_FULL : ST_PUSHED;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the queue");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (m_tvalid && m_tuser == ST_POPPED))
        else $error("pop gave no popped result");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (entry_w[0].deadline <= entry_w[1].deadline))
        else $error("head cells out of order");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the earliest-deadline-first ready queue. Push and
// pop words go in on the slave stream; a scoreboard keeps its own copy of the
// ready list, predicts every result word and compares each one that leaves
// the master stream. Directed words cover empty, full, ties and field
// extremes; random words run under several idle and stall patterns,
// including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import edfq_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200000;

    typedef struct {
        status_t           status;
        logic [KIND_W-1:0] kind;
        logic [DL_W-1:0]   deadline;
    } result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    entry_t      ready_list[$];
    result_t     pending_results[$];
    int unsigned mismatches     = 0;
    int unsigned cycles         = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_cycles    = 0;
    int unsigned held           = 0;

    edf_ready_queue_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("edf_ready_queue_core verification failed");
            $finish;
        end
    end

    // receiver: long hold-off first, random stalls otherwise
    always @(posedge clk)
    begin
        if (held < hold_cycles)
        begin
            m_tready <= 1'b0;
            held++;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic result_t edf_apply(input mode_t m, input logic [DL_W-1:0] dl,
                                          input logic [KIND_W-1:0] k);
        result_t r;
        entry_t  e;
        int      best;
        r.status   = ST_PUSHED;
        r.kind     = '0;
        r.deadline = '0;
        if (m == MODE_PUSH)
        begin
            if (ready_list.size() >= QUEUE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                e.deadline = dl;
                e.kind     = k;
                ready_list.insert(ready_list.size(), e);
            end
        end
        else if (ready_list.size() == 0)
            r.status = ST_EMPTY;
        else
        begin
            // strict compare keeps the oldest of equal deadlines
            best = 0;
            for (int i = 1; i < ready_list.size(); i++)
                if (ready_list[i].deadline < ready_list[best].deadline)
                    best = i;
            r.status   = ST_POPPED;
            r.kind     = ready_list[best].kind;
            r.deadline = ready_list[best].deadline;
            ready_list.delete(best);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result word, status", m_tuser, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[KIND_W-1:0] !== want.kind)
                    report_mismatch("out_task_kind", m_tdata[KIND_W-1:0], want.kind);
                if (m_tdata[KIND_W+DL_W-1:KIND_W] !== want.deadline)
                    report_mismatch("out_deadline", m_tdata[KIND_W+DL_W-1:KIND_W],
                                    want.deadline);
            end
        end
    end

    task automatic send_word(input mode_t m, input logic [DL_W-1:0] dl,
                             input logic [KIND_W-1:0] k);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {{(IN_DATA_W-DL_W-KIND_W){1'b0}}, k, dl};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        pending_results.insert(pending_results.size(), edf_apply(m, dl, k));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [DL_W-1:0] pick_deadline();
        case ($urandom_range(3))
            0:       return $urandom_range(7);
            1:       return $urandom_range(1) ? '1 : '0;
            2:       return '1 - $urandom_range(15);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_extremes();
        send_word(MODE_POP, '1, 3'd7);
        send_word(MODE_PUSH, '1, 3'd7);
        send_word(MODE_PUSH, '0, 3'd0);
        send_word(MODE_PUSH, 32'h8000_0000, 3'd6);
        send_word(MODE_POP, '0, 3'd0);
        send_word(MODE_POP, 32'h5555_5555, 3'd5);
        send_word(MODE_POP, '0, 3'd0);
        send_word(MODE_POP, '1, 3'd7);
        drain_results();
    endtask

    task automatic test_tie_order();
        send_word(MODE_PUSH, 32'd5, 3'd1);
        send_word(MODE_PUSH, 32'd5, 3'd2);
        send_word(MODE_PUSH, 32'd3, 3'd6);
        send_word(MODE_PUSH, 32'd5, 3'd3);
        repeat (4) send_word(MODE_POP, '0, 3'd0);
        drain_results();
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_word(MODE_PUSH, 32'(QUEUE_DEPTH - i / 2), 3'($urandom_range(7)));
        send_word(MODE_PUSH, '0, 3'd4);
        send_word(MODE_POP, '0, 3'd0);
        send_word(MODE_PUSH, '1, 3'd5);
        send_word(MODE_PUSH, 32'd1, 3'd2);
        drain_results();
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = held + 300;
        for (int i = 0; i < 30; i++)
            send_word((i < 20) ? MODE_PUSH : MODE_POP, pick_deadline(),
                      3'($urandom_range(7)));
        drain_results();
    endtask

    task automatic test_random_mix(input int unsigned n, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
        int unsigned push_pct;
        mode_t       m;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        push_pct       = 50;
        for (int i = 0; i < n; i++)
        begin
            // swing the fill level between empty and full
            if (i % 25 == 0)
                push_pct = 15 + 20 * $urandom_range(3);
            m = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
            send_word(m, pick_deadline(), 3'($urandom_range(7)));
        end
        drain_results();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_tie_order();
        test_full_queue();
        test_backpressure();
        test_random_mix(125, 0, 0);
        test_random_mix(125, 87, 0);
        test_random_mix(125, 0, 87);
        test_random_mix(125, 23, 23);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("edf_ready_queue_core verification clean");
        else
            $display("edf_ready_queue_core verification failed");
        $finish;
    end

endmodule
